// ===== hdl/rgb565_gray_color_centroid_defines.svh =====
// Assertion macros shared by the color centroid block.
`ifndef RGB565_GRAY_COLOR_CENTROID_DEFINES_SVH
`define RGB565_GRAY_COLOR_CENTROID_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RGCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgcc: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define RGCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgcc: next-cycle check failed");

`endif

// ===== hdl/rgcc_pkg.sv =====
// Types and constants shared by the color centroid block.
package rgcc_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int COLOR_W    = 8;
  localparam int COUNT_W    = 21;
  localparam int TOTAL_W    = 30;
  localparam int CENTER_W   = 10;
  localparam int STEP_W     = $clog2(TOTAL_W);

  // Luma weights for 8-bit expanded channels
  localparam logic [15:0] GRAY_WR = 16'd54;
  localparam logic [15:0] GRAY_WG = 16'd183;
  localparam logic [15:0] GRAY_WB = 16'd19;

  // Result kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED_LOW,
    CFG_RED_HIGH,
    CFG_GREEN_LOW,
    CFG_GREEN_HIGH,
    CFG_BLUE_LOW,
    CFG_BLUE_HIGH,
    CFG_LINE_WIDTH,
    CFG_FRAME_LINES
  } cfg_index_t;

  // Register reset values
  localparam logic [COLOR_W-1:0]    RST_RED_LOW     = 8'd60;
  localparam logic [COLOR_W-1:0]    RST_RED_HIGH    = 8'd100;
  localparam logic [COLOR_W-1:0]    RST_GREEN_LOW   = 8'd0;
  localparam logic [COLOR_W-1:0]    RST_GREEN_HIGH  = 8'd40;
  localparam logic [COLOR_W-1:0]    RST_BLUE_LOW    = 8'd20;
  localparam logic [COLOR_W-1:0]    RST_BLUE_HIGH   = 8'd60;
  localparam logic [CFG_DATA_W-1:0] RST_LINE_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_LINES = 11'd480;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIVIDE,
    ST_SUMMARY
  } state_t;

  typedef struct packed {
    logic take_pixel;
    logic start_div;
    logic step_div;
    logic load_summary;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic out_busy;
    logic div_done;
  } status_t;

endpackage

// ===== hdl/rgb565_gray_color_centroid.sv =====
// Top level of the RGB565 grayscale converter with color centroid detection.
//
// Input channel: one RGB565 pixel per transaction (in_valid, in_stall,
// pixel_rgb565), in raster order. Output channel: results with out_valid and
// out_stall. Each pixel yields a gray result (kind 0) the cycle after it is
// taken. The last pixel of a frame also yields a frame summary (kind 1):
// detected flag plus centroid line and column, with last set (last is also
// set on every gray result but the frame's final one). Throughput is one
// pixel per cycle while the receiver keeps up. After the final pixel of a
// frame the input stalls while the two bit-serial dividers run (one quotient
// bit each per cycle, in parallel) and the summary waits for a free output.
// A single output register separates the channels: a new pixel is taken in
// the same cycle that the waiting result leaves; while the receiver stalls,
// the result holds and in_stall is raised.
// Reset (synchronous, rst high) restores the default thresholds and
// geometry, clears position and accumulators and empties the output.
// Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
// once and are meant for idle periods between frames.
module rgb565_gray_color_centroid #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LINES  = 1024,
  parameter int DETECT_MIN = 100
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [rgcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      pixel_rgb565,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             kind,
  output logic [7:0]                       gray,
  output logic                             detected,
  output logic [rgcc_pkg::CENTER_W-1:0]    center_line,
  output logic [rgcc_pkg::CENTER_W-1:0]    center_pixel,
  output logic                             last
);

  `include "rgb565_gray_color_centroid_defines.svh"

  rgcc_pkg::cmd_t    cmd;
  rgcc_pkg::status_t status;

  rgcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  rgcc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LINES  (MAX_LINES),
    .DETECT_MIN (DETECT_MIN)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_rgb565 (pixel_rgb565),
    .out_stall    (out_stall),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .kind         (kind),
    .gray         (gray),
    .detected     (detected),
    .center_line  (center_line),
    .center_pixel (center_pixel),
    .last         (last)
  );

  // A summary is always the final result of its pixel
  `RGCC_ASSERT_SAME(a_summary_last, out_valid && kind, last)
  // No pixel enters while the dividers run
  `RGCC_ASSERT_SAME(a_no_take_in_div, cmd.step_div, in_stall)
  // A frame-end transaction blocks the next pixel
  `RGCC_ASSERT_NEXT(a_frame_end_stall, in_valid && !in_stall && status.frame_end, in_stall)
  // Never overwrite a result still waiting on the receiver
  `RGCC_ASSERT_SAME(a_no_overwrite, cmd.take_pixel || cmd.load_summary, !status.out_busy)

endmodule

// ===== hdl/rgcc_divider.sv =====
// Bit-serial restoring divider, one quotient bit per step.
module rgcc_divider (
  input  logic                             clk,
  input  logic                             start,
  input  logic                             step,
  input  logic [rgcc_pkg::TOTAL_W-1:0]     dividend,
  input  logic [rgcc_pkg::COUNT_W-1:0]     divisor,
  output logic [rgcc_pkg::TOTAL_W-1:0]     quotient
);

  logic [rgcc_pkg::COUNT_W-1:0] div_reg;
  logic [rgcc_pkg::COUNT_W-1:0] rem;
  logic [rgcc_pkg::COUNT_W:0]   rem_sh;
  logic [rgcc_pkg::COUNT_W:0]   rem_diff;
  logic                         fits;

  // Shift in the next dividend bit and trial subtract
  always_comb begin
    rem_sh   = {rem, quotient[rgcc_pkg::TOTAL_W-1]};
    rem_diff = rem_sh - {1'b0, div_reg};
    fits     = (rem_sh >= {1'b0, div_reg});
  end

  // Load operands, then advance one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      div_reg  <= divisor;
      rem      <= '0;
    end else if (step) begin
      quotient <= {quotient[rgcc_pkg::TOTAL_W-2:0], fits};
      rem      <= fits ? rem_diff[rgcc_pkg::COUNT_W-1:0] : rem_sh[rgcc_pkg::COUNT_W-1:0];
    end
  end

endmodule

// ===== hdl/rgcc_datapath.sv =====
// Datapath: config registers, gray conversion, match accumulators, dividers, output register.
module rgcc_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LINES  = 1024,
  parameter int DETECT_MIN = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [rgcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [15:0]                         pixel_rgb565,
  input  logic                                out_stall,
  input  rgcc_pkg::cmd_t                      cmd,
  output rgcc_pkg::status_t                   status,
  output logic                                out_valid,
  output logic                                kind,
  output logic [7:0]                          gray,
  output logic                                detected,
  output logic [rgcc_pkg::CENTER_W-1:0]       center_line,
  output logic [rgcc_pkg::CENTER_W-1:0]       center_pixel,
  output logic                                last
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int LIN_W  = $clog2(MAX_LINES);
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > rgcc_pkg::CFG_DATA_W) ?
                          $clog2(MAX_WIDTH + 1) : rgcc_pkg::CFG_DATA_W;
  localparam int LCMP_W = ($clog2(MAX_LINES + 1) > rgcc_pkg::CFG_DATA_W) ?
                          $clog2(MAX_LINES + 1) : rgcc_pkg::CFG_DATA_W;

  logic [rgcc_pkg::COLOR_W-1:0]    red_low, red_high, green_low, green_high;
  logic [rgcc_pkg::COLOR_W-1:0]    blue_low, blue_high;
  logic [rgcc_pkg::CFG_DATA_W-1:0] line_width, frame_lines;

  logic [COL_W-1:0]             column_pos;
  logic [LIN_W-1:0]             line_pos;
  logic [rgcc_pkg::COUNT_W-1:0] match_count, match_count_next;
  logic [rgcc_pkg::TOTAL_W-1:0] line_total, line_total_next;
  logic [rgcc_pkg::TOTAL_W-1:0] column_total, column_total_next;
  logic [rgcc_pkg::STEP_W-1:0]  step_cnt;
  logic                         det_flag;

  logic [7:0]                   r8, g8, b8;
  logic [15:0]                  gray_sum;
  logic                         match;
  logic [WCMP_W-1:0]            width_cfg, width_eff, col_plus;
  logic [LCMP_W-1:0]            lines_cfg, lines_eff, lin_plus;
  logic                         line_end;
  logic [rgcc_pkg::TOTAL_W-1:0] line_quot, col_quot;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_low     <= rgcc_pkg::RST_RED_LOW;
      red_high    <= rgcc_pkg::RST_RED_HIGH;
      green_low   <= rgcc_pkg::RST_GREEN_LOW;
      green_high  <= rgcc_pkg::RST_GREEN_HIGH;
      blue_low    <= rgcc_pkg::RST_BLUE_LOW;
      blue_high   <= rgcc_pkg::RST_BLUE_HIGH;
      line_width  <= rgcc_pkg::RST_LINE_WIDTH;
      frame_lines <= rgcc_pkg::RST_FRAME_LINES;
    end else if (cfg_write_en) begin
      unique case (rgcc_pkg::cfg_index_t'(cfg_index))
        rgcc_pkg::CFG_RED_LOW:     red_low     <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_RED_HIGH:    red_high    <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_GREEN_LOW:   green_low   <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_GREEN_HIGH:  green_high  <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_BLUE_LOW:    blue_low    <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_BLUE_HIGH:   blue_high   <= cfg_data[rgcc_pkg::COLOR_W-1:0];
        rgcc_pkg::CFG_LINE_WIDTH:  line_width  <= cfg_data;
        rgcc_pkg::CFG_FRAME_LINES: frame_lines <= cfg_data;
      endcase
    end
  end

  // Expand channels, compute gray and the color match
  always_comb begin
    r8       = {pixel_rgb565[15:11], 3'b000};
    g8       = {pixel_rgb565[10:5], 2'b00};
    b8       = {pixel_rgb565[4:0], 3'b000};
    gray_sum = 16'(r8) * rgcc_pkg::GRAY_WR + 16'(g8) * rgcc_pkg::GRAY_WG
             + 16'(b8) * rgcc_pkg::GRAY_WB;
    match    = (red_low < r8) && (r8 < red_high) &&
               (green_low < g8) && (g8 < green_high) &&
               (blue_low < b8) && (b8 < blue_high);
  end

  // Clamp geometry and detect line end
  always_comb begin
    width_cfg = WCMP_W'(line_width);
    if (width_cfg == '0)                     width_eff = WCMP_W'(1);
    else if (width_cfg > WCMP_W'(MAX_WIDTH)) width_eff = WCMP_W'(MAX_WIDTH);
    else                                     width_eff = width_cfg;
    lines_cfg = LCMP_W'(frame_lines);
    if (lines_cfg == '0)                     lines_eff = LCMP_W'(1);
    else if (lines_cfg > LCMP_W'(MAX_LINES)) lines_eff = LCMP_W'(MAX_LINES);
    else                                     lines_eff = lines_cfg;
    col_plus = WCMP_W'(column_pos) + WCMP_W'(1);
    lin_plus = LCMP_W'(line_pos) + LCMP_W'(1);
    line_end = (col_plus >= width_eff);
  end

  // Accumulate matching pixels
  always_comb begin
    match_count_next  = match_count;
    line_total_next   = line_total;
    column_total_next = column_total;
    if (match) begin
      match_count_next  = match_count + rgcc_pkg::COUNT_W'(1);
      line_total_next   = line_total + rgcc_pkg::TOTAL_W'(line_pos);
      column_total_next = column_total + rgcc_pkg::TOTAL_W'(column_pos);
    end
  end

  // Advance position and accumulators; clear them at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos   <= '0;
      line_pos     <= '0;
      match_count  <= '0;
      line_total   <= '0;
      column_total <= '0;
    end else if (cmd.take_pixel) begin
      if (line_end) begin
        column_pos <= '0;
        line_pos   <= status.frame_end ? '0 : LIN_W'(lin_plus);
      end else begin
        column_pos <= COL_W'(col_plus);
      end
      if (cmd.start_div) begin
        match_count  <= '0;
        line_total   <= '0;
        column_total <= '0;
      end else begin
        match_count  <= match_count_next;
        line_total   <= line_total_next;
        column_total <= column_total_next;
      end
    end
  end

  // Count divider steps and hold the detect flag
  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      step_cnt <= '0;
      det_flag <= (match_count_next > rgcc_pkg::COUNT_W'(DETECT_MIN)) &&
                  (match_count_next != '0);
    end else if (cmd.step_div) begin
      step_cnt <= step_cnt + rgcc_pkg::STEP_W'(1);
    end
  end

  rgcc_divider u_div_line (
    .clk      (clk),
    .start    (cmd.start_div),
    .step     (cmd.step_div),
    .dividend (line_total_next),
    .divisor  (match_count_next),
    .quotient (line_quot)
  );

  rgcc_divider u_div_col (
    .clk      (clk),
    .start    (cmd.start_div),
    .step     (cmd.step_div),
    .dividend (column_total_next),
    .divisor  (match_count_next),
    .quotient (col_quot)
  );

  // Report status to the controller
  always_comb begin
    status.frame_end = line_end && (lin_plus >= lines_eff);
    status.out_busy  = out_valid && out_stall;
    status.div_done  = (step_cnt == rgcc_pkg::STEP_W'(rgcc_pkg::TOTAL_W - 1));
  end

  // Output register: load a result, drop it once the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.take_pixel || cmd.load_summary) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_pixel) begin
      kind         <= rgcc_pkg::KIND_PIXEL;
      gray         <= gray_sum[15:8];
      detected     <= 1'b0;
      center_line  <= '0;
      center_pixel <= '0;
      last         <= !status.frame_end;
    end else if (cmd.load_summary) begin
      kind         <= rgcc_pkg::KIND_SUMMARY;
      gray         <= '0;
      detected     <= det_flag;
      center_line  <= det_flag ? line_quot[rgcc_pkg::CENTER_W-1:0] : '0;
      center_pixel <= det_flag ? col_quot[rgcc_pkg::CENTER_W-1:0] : '0;
      last         <= 1'b1;
    end
  end

endmodule

// ===== hdl/rgcc_ctrl.sv =====
// Controller: sequences pixel intake, centroid division and summary output.
module rgcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rgcc_pkg::status_t status,
  output logic              in_stall,
  output rgcc_pkg::cmd_t    cmd
);

  rgcc_pkg::state_t state, state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgcc_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rgcc_pkg::ST_RUN: begin
        if (in_valid && !status.out_busy && status.frame_end) state_next = rgcc_pkg::ST_DIVIDE;
      end
      rgcc_pkg::ST_DIVIDE: begin
        if (status.div_done) state_next = rgcc_pkg::ST_SUMMARY;
      end
      rgcc_pkg::ST_SUMMARY: begin
        if (!status.out_busy) state_next = rgcc_pkg::ST_RUN;
      end
      default: state_next = rgcc_pkg::ST_RUN;
    endcase
  end

  // Commands and input stall
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      rgcc_pkg::ST_RUN: begin
        in_stall       = status.out_busy;
        cmd.take_pixel = in_valid && !status.out_busy;
        cmd.start_div  = in_valid && !status.out_busy && status.frame_end;
      end
      rgcc_pkg::ST_DIVIDE: begin
        cmd.step_div = 1'b1;
      end
      rgcc_pkg::ST_SUMMARY: begin
        cmd.load_summary = !status.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== dv/gray_centroid_checker.sv =====
// Checker for the color centroid block: watches both channels, predicts and compares results.
module gray_centroid_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_LINES  = 1024,
  parameter int DETECT_MIN = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [rgcc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rgcc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [15:0]                         pixel_rgb565,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                kind,
  input  logic [7:0]                          gray,
  input  logic                                detected,
  input  logic [rgcc_pkg::CENTER_W-1:0]       center_line,
  input  logic [rgcc_pkg::CENTER_W-1:0]       center_pixel,
  input  logic                                last,
  output int                                  error_count,
  output int                                  pending_results,
  output int                                  summary_count,
  output int                                  detect_count
);
  import rgcc_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic       kind;
    logic [7:0] gray;
    logic       detected;
    logic [9:0] line_mean;
    logic [9:0] col_mean;
    logic       last;
  } result_t;

  // Shadow of the block: registers, raster position, frame accumulators
  logic [CFG_DATA_W-1:0] cfg_regs [0:7];
  int unsigned           col_pos;
  int unsigned           line_pos;
  logic [COUNT_W-1:0]    match_count;
  logic [TOTAL_W-1:0]    line_sum;
  logic [TOTAL_W-1:0]    col_sum;

  result_t expected_q [$];
  result_t got_res;
  result_t want_res;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Compute the gray result of one pixel, update the frame state and queue
  // the frame summary when the pixel closes the frame.
  function automatic void predict_gray_and_centroid(input logic [15:0] px);
    int unsigned red, grn, blu, luma, width, height;
    bit          frame_end;
    result_t     res;
    red = {px[15:11], 3'b000};
    grn = {px[10:5], 2'b00};
    blu = {px[4:0], 3'b000};
    luma = (red * GRAY_WR + grn * GRAY_WG + blu * GRAY_WB) >> 8;
    width = clamp_dim(cfg_regs[CFG_LINE_WIDTH], MAX_WIDTH);
    height = clamp_dim(cfg_regs[CFG_FRAME_LINES], MAX_LINES);
    frame_end = 1'b0;

    // Accumulate pixels strictly inside all three bounds
    if (red > cfg_regs[CFG_RED_LOW] && red < cfg_regs[CFG_RED_HIGH] &&
        grn > cfg_regs[CFG_GREEN_LOW] && grn < cfg_regs[CFG_GREEN_HIGH] &&
        blu > cfg_regs[CFG_BLUE_LOW] && blu < cfg_regs[CFG_BLUE_HIGH]) begin
      match_count = match_count + 1'b1;
      line_sum = line_sum + TOTAL_W'(line_pos);
      col_sum = col_sum + TOTAL_W'(col_pos);
    end

    // Advance the raster position; a shrunken geometry ends the line or frame at once
    if (col_pos + 1 >= width) begin
      col_pos = 0;
      if (line_pos + 1 >= height) begin
        line_pos = 0;
        frame_end = 1'b1;
      end else begin
        line_pos++;
      end
    end else begin
      col_pos++;
    end

    res = '0;
    res.kind = KIND_PIXEL;
    res.gray = luma[7:0];
    res.last = !frame_end;
    expected_q.push_back(res);

    if (frame_end) begin
      res = '0;
      res.kind = KIND_SUMMARY;
      res.last = 1'b1;
      if (match_count > DETECT_MIN) begin
        res.detected = 1'b1;
        res.line_mean = 10'(line_sum / match_count);
        res.col_mean = 10'(col_sum / match_count);
      end
      expected_q.push_back(res);
      match_count = '0;
      line_sum = '0;
      col_sum = '0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_regs[CFG_RED_LOW] = RST_RED_LOW;
      cfg_regs[CFG_RED_HIGH] = RST_RED_HIGH;
      cfg_regs[CFG_GREEN_LOW] = RST_GREEN_LOW;
      cfg_regs[CFG_GREEN_HIGH] = RST_GREEN_HIGH;
      cfg_regs[CFG_BLUE_LOW] = RST_BLUE_LOW;
      cfg_regs[CFG_BLUE_HIGH] = RST_BLUE_HIGH;
      cfg_regs[CFG_LINE_WIDTH] = RST_LINE_WIDTH;
      cfg_regs[CFG_FRAME_LINES] = RST_FRAME_LINES;
      col_pos = 0;
      line_pos = 0;
      match_count = '0;
      line_sum = '0;
      col_sum = '0;
      expected_q.delete();
      error_count = 0;
      summary_count = 0;
      detect_count = 0;
    end else begin
      // Check the output transaction against the oldest expectation
      if (out_valid && !out_stall) begin
        got_res = {kind, gray, detected, center_line, center_pixel, last};
        if (expected_q.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result: kind=%0d gray=%0d det=%0d line=%0d col=%0d last=%0d",
                     got_res.kind, got_res.gray, got_res.detected, got_res.line_mean,
                     got_res.col_mean, got_res.last);
        end else begin
          want_res = expected_q.pop_front();
          if (want_res.kind == KIND_SUMMARY) begin
            summary_count++;
            if (want_res.detected) detect_count++;
          end
          if (got_res !== want_res) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("result mismatch: expected kind=%0d gray=%0d det=%0d line=%0d col=%0d last=%0d",
                       want_res.kind, want_res.gray, want_res.detected, want_res.line_mean,
                       want_res.col_mean, want_res.last);
              $display("  actual kind=%0d gray=%0d det=%0d line=%0d col=%0d last=%0d",
                       got_res.kind, got_res.gray, got_res.detected, got_res.line_mean,
                       got_res.col_mean, got_res.last);
            end
          end
        end
      end

      // Predict results of the input transaction
      if (in_valid && !in_stall)
        predict_gray_and_centroid(pixel_rgb565);

      // Mirror register writes; color bounds keep eight bits
      if (cfg_write_en)
        cfg_regs[cfg_index] = (cfg_index <= CFG_BLUE_HIGH) ? {3'b000, cfg_data[7:0]} : cfg_data;
    end
    pending_results = expected_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the color centroid block: clock, reset, stimulus and verdict.
module tb_top;
  import rgcc_pkg::*;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_LINES    = 1024;
  localparam int DETECT_MIN   = 100;
  localparam int ITEM_TARGET  = 1250;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_write_en = 1'b0;
  cfg_index_t            cfg_index = CFG_RED_LOW;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [15:0]           pixel_rgb565 = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  kind;
  logic [7:0]            gray;
  logic                  detected;
  logic [CENTER_W-1:0]   center_line;
  logic [CENTER_W-1:0]   center_pixel;
  logic                  last;

  int error_count;
  int pending_results;
  int summary_count;
  int detect_count;
  int pixels_sent = 0;
  int cycle_count = 0;
  int in_gap_pct = 0;
  int out_gap_pct = 20;
  int stall_left = 0;

  // Channel code ranges that fall strictly inside the current bounds
  int match_lo [3];
  int match_hi [3];

  // Opening pixels: channel extremes, bit patterns, edges of the reset bounds
  logic [15:0] px_list [14] = '{
    16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hAAAA, 16'h5555,
    16'h48A5,   // inside all reset bounds
    16'h40A5,   // lowest red code inside
    16'h38A5,   // red just below the low bound
    16'h60A5,   // highest red code inside
    16'h4945,   // green equal to the high bound
    16'h48A3,   // lowest blue code inside
    16'h48A2    // blue just below the low bound
  };

  rgb565_gray_color_centroid #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES),
    .DETECT_MIN(DETECT_MIN)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write_en(cfg_write_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_rgb565(pixel_rgb565),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .gray        (gray),
    .detected    (detected),
    .center_line (center_line),
    .center_pixel(center_pixel),
    .last        (last)
  );

  gray_centroid_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_LINES (MAX_LINES),
    .DETECT_MIN(DETECT_MIN)
  ) i_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_rgb565   (pixel_rgb565),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .gray           (gray),
    .detected       (detected),
    .center_line    (center_line),
    .center_pixel   (center_pixel),
    .last           (last),
    .error_count    (error_count),
    .pending_results(pending_results),
    .summary_count  (summary_count),
    .detect_count   (detect_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < out_gap_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 13);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one pixel, hold it until the transaction completes, then maybe idle
  task automatic push_pixel(input logic [15:0] px);
    in_valid <= 1'b1;
    pixel_rgb565 <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pixels_sent++;
    if ($urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has left the block
  task automatic settle(input int margin);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
  endtask

  // Drive a register write and wait for the clock; the caller drops the enable
  task automatic write_reg(input cfg_index_t idx, input int unsigned val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
  endtask

  function automatic int pick3(input int a, input int b, input int c);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      default: return c;
    endcase
  endfunction

  function automatic logic [15:0] matching_pixel();
    logic [4:0] rc;
    logic [5:0] gc;
    logic [4:0] bc;
    rc = 5'($urandom_range(match_hi[0], match_lo[0]));
    gc = 6'($urandom_range(match_hi[1], match_lo[1]));
    bc = 5'($urandom_range(match_hi[2], match_lo[2]));
    return {rc, gc, bc};
  endfunction

  initial begin
    int mode, shape, w, h, frames, match_pct, n_px;
    int ch_step, top_code, code_a, code_b, lo_val, hi_val;

    // Codes that match the reset bounds
    match_lo = '{8, 1, 3};
    match_hi = '{12, 9, 7};

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extremes and default-bound edges inside a 640-wide frame
    foreach (px_list[i]) push_pixel(px_list[i]);

    // Zero width mid-frame ends the line; zero lines then ends the frame
    settle(4);
    write_reg(CFG_LINE_WIDTH, 0);
    cfg_write_en <= 1'b0;
    push_pixel(16'h48A5);
    settle(4);
    write_reg(CFG_FRAME_LINES, 0);
    cfg_write_en <= 1'b0;
    push_pixel(16'h48A5);

    while (pixels_sent < ITEM_TARGET) begin
      settle(4);

      // Quiet tail: no idling on either side
      if (pixels_sent > ITEM_TARGET * 9 / 10) begin
        in_gap_pct = 0;
        out_gap_pct <= 0;
      end else begin
        in_gap_pct = pick3(0, 10, 40);
        out_gap_pct <= pick3(0, 10, 40);
      end

      mode = $urandom_range(0, 9);
      if (mode <= 8) begin
        // Bounds: around a target color for detection frames, arbitrary otherwise
        for (int ch = 0; ch < 3; ch++) begin
          ch_step = (ch == 1) ? 4 : 8;
          top_code = (ch == 1) ? 63 : 31;
          if (mode <= 5) begin
            code_a = $urandom_range(1, top_code);
            code_b = $urandom_range(1, top_code);
            match_lo[ch] = (code_a < code_b) ? code_a : code_b;
            match_hi[ch] = (code_a < code_b) ? code_b : code_a;
            lo_val = match_lo[ch] * ch_step - $urandom_range(1, ch_step);
            hi_val = match_hi[ch] * ch_step + $urandom_range(1, ch_step);
            if (hi_val > 255) hi_val = 255;
          end else begin
            lo_val = pick3(0, 255, $urandom_range(0, 255));
            hi_val = pick3(0, 255, $urandom_range(0, 255));
          end
          case (ch)
            0: begin
              write_reg(CFG_RED_LOW, lo_val);
              write_reg(CFG_RED_HIGH, hi_val);
            end
            1: begin
              write_reg(CFG_GREEN_LOW, lo_val);
              write_reg(CFG_GREEN_HIGH, hi_val);
            end
            default: begin
              write_reg(CFG_BLUE_LOW, lo_val);
              write_reg(CFG_BLUE_HIGH, hi_val);
            end
          endcase
        end

        if (mode <= 5) begin
          // Detection frames, including counts right at the threshold
          shape = $urandom_range(0, 9);
          match_pct = 100;
          if (shape == 0) begin
            w = 10;
            h = 10;
          end else if (shape == 1) begin
            w = 101;
            h = 1;
          end else if (shape == 2) begin
            w = 1;
            h = 101;
          end else begin
            w = $urandom_range(6, 16);
            h = (120 + w - 1) / w + $urandom_range(0, 3);
            match_pct = pick3(100, 95, 80);
          end
          frames = $urandom_range(1, 2);
        end else begin
          // Tiny frames with noise, zero geometry included
          w = $urandom_range(0, 5);
          h = $urandom_range(0, 5);
          frames = $urandom_range(1, 6);
          match_pct = 30;
        end
        write_reg(CFG_LINE_WIDTH, w);
        write_reg(CFG_FRAME_LINES, h);
        cfg_write_en <= 1'b0;
        n_px = frames * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        repeat (n_px) begin
          if ($urandom_range(0, 99) < match_pct) push_pixel(matching_pixel());
          else push_pixel(16'($urandom()));
        end
      end else begin
        // Oversize geometry: part of a frame, then shrink it to close the frame
        if ($urandom_range(0, 1) == 1) begin
          write_reg(CFG_LINE_WIDTH, pick3(1024, 1025, 2047));
          write_reg(CFG_FRAME_LINES, $urandom_range(2, 6));
        end else begin
          write_reg(CFG_LINE_WIDTH, 1);
          write_reg(CFG_FRAME_LINES, pick3(1024, 2047, 1025));
        end
        cfg_write_en <= 1'b0;
        repeat ($urandom_range(5, 20)) push_pixel(16'($urandom()));
        settle(4);
        write_reg(CFG_LINE_WIDTH, 1);
        write_reg(CFG_FRAME_LINES, 1);
        cfg_write_en <= 1'b0;
        push_pixel(16'($urandom()));
      end
    end

    // Drain and decide
    settle(DRAIN_CYCLES);
    $display("covered %0d pixels and %0d frame summaries, %0d of them with a detection",
             pixels_sent, summary_count, detect_count);
    if (error_count == 0 && pending_results == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d, results still owed: %0d", error_count, pending_results);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
